FILE: rtl/plt_pkg.sv
// Shared constants, codes and interface types of the interpolation table.
package plt_pkg;
   localparam int MAX_POINTS = 64;
   localparam int AW         = $clog2(MAX_POINTS);
   localparam int CW         = $clog2(MAX_POINTS + 1);
   localparam int WX         = 32;
   localparam int DW         = WX + 1;
   localparam int PW         = 2 * DW;
   localparam int QBITS      = 40;
   localparam int QW         = QBITS + 1;
   localparam int SW         = QW + 1;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_ZERO_WIDTH = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_SAT        = 3'd4;

   typedef struct packed {
      logic                 start;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic [WX-1:0]        den;
   } md_req_type;

   typedef struct packed {
      logic          done;
      logic          neg;
      logic [QW-1:0] q;
   } md_rsp_type;
endpackage

FILE: rtl/plt_muldiv.sv
// Serial multiply of slope terms followed by restoring division.
module plt_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  plt_pkg::md_req_type md_req,
   output plt_pkg::md_rsp_type md_rsp
);
   import plt_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_type;

   mstate_type       mstate_ff;
   logic [DW-1:0]    a_ff;
   logic [DW-1:0]    b_ff;
   logic [WX-1:0]    d_ff;
   logic [PW-1:0]    p_ff;
   logic [WX-1:0]    rem_ff;
   logic [QBITS-1:0] q_ff;
   logic             big_ff;
   logic             neg_ff;
   logic             done_ff;
   logic [6:0]       cnt_ff;
   logic [WX:0]      r2;
   logic             ge;
   logic [WX:0]      diff;

   assign r2   = {rem_ff, p_ff[PW-1]};
   assign ge   = r2 >= {1'b0, d_ff};
   assign diff = r2 - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff <= M_IDLE;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (mstate_ff)
            M_IDLE: begin
               if (md_req.start) begin
                  a_ff      <= md_req.dx[DW-1] ? DW'(-md_req.dx) : md_req.dx;
                  b_ff      <= md_req.dy[DW-1] ? DW'(-md_req.dy) : md_req.dy;
                  neg_ff    <= md_req.dx[DW-1] ^ md_req.dy[DW-1];
                  d_ff      <= md_req.den;
                  p_ff      <= '0;
                  cnt_ff    <= 7'(DW - 1);
                  mstate_ff <= M_MUL;
               end
            end
            M_MUL: begin
               p_ff <= {p_ff[PW-2:0], 1'b0} +
                       (b_ff[DW-1] ? {{(PW-DW){1'b0}}, a_ff} : '0);
               b_ff <= {b_ff[DW-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  cnt_ff    <= 7'(PW - 1);
                  rem_ff    <= '0;
                  q_ff      <= '0;
                  big_ff    <= 1'b0;
                  mstate_ff <= M_DIV;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            M_DIV: begin
               rem_ff <= ge ? diff[WX-1:0] : r2[WX-1:0];
               p_ff   <= {p_ff[PW-2:0], 1'b0};
               if (cnt_ff >= 7'(QBITS)) begin
                  big_ff <= big_ff | ge;
               end else begin
                  q_ff <= {q_ff[QBITS-2:0], ge};
               end
               if (cnt_ff == '0) begin
                  done_ff   <= 1'b1;
                  mstate_ff <= M_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: mstate_ff <= M_IDLE;
         endcase
      end
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.neg  = neg_ff;
   assign md_rsp.q    = big_ff ? (QW'(1) << QBITS) : {1'b0, q_ff};
endmodule

FILE: rtl/piecewise_linear_interp_table_core.sv
// Piecewise linear interpolation table: sorted breakpoint store with lookup.
// Breakpoints live in two two-port memories (x and y, 64 entries each,
// registered read). An add scans from the top entry down, moving one entry
// per cycle. A lookup does a binary search, then a serial multiply and a
// restoring divide, and extrapolates from the end segment outside the range.
// A single-point lookup returns that point; a zero-width end segment gives
// a zero-width status. Clear, unknown commands, a full-table add and an
// empty lookup go straight to the response. One item is in work at a time;
// a finished result waits in the output register while the next item is
// taken.
module piecewise_linear_interp_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x_value[31:0], y_value[63:32]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_y[31:0], point_count[38:32], zero[39]
   output logic [2:0]  rsp_tuser    // status[2:0]
);
   import plt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_X0, S_INS_EVAL, S_INS_WR,
      S_LK_X0, S_LK_XL, S_LK_SRCH, S_LK_SCMP,
      S_LK_F0, S_LK_F1, S_LK_F2, S_LK_GO, S_LK_DIV, S_EMIT
   } state_type;

   state_type            state_ff;
   logic [CW-1:0]        count_ff;
   logic signed [WX-1:0] xv_ff;
   logic signed [WX-1:0] yv_ff;
   logic                 front_ff;
   logic [AW-1:0]        idx_ff;
   logic [AW-1:0]        lo_ff;
   logic [AW-1:0]        hi_ff;
   logic [AW-1:0]        mid_ff;
   logic [AW-1:0]        s0_ff;
   logic [AW-1:0]        s1_ff;
   logic                 anc_hi_ff;
   logic signed [WX-1:0] x0_ff;
   logic signed [WX-1:0] xs0_ff;
   logic signed [WX-1:0] ys0_ff;
   logic signed [WX-1:0] ya_ff;
   logic signed [WX-1:0] res_ff;
   logic [2:0]           st_ff;
   logic                 rsp_valid_ff;
   logic [WX-1:0]        rsp_y_ff;
   logic [2:0]           rsp_st_ff;
   logic [CW-1:0]        rsp_cnt_ff;
   md_req_type           md_req_ff;
   md_rsp_type           md_rsp;

   logic signed [WX-1:0] x_mem [MAX_POINTS];
   logic signed [WX-1:0] y_mem [MAX_POINTS];
   logic signed [WX-1:0] rx_ff;
   logic signed [WX-1:0] ry_ff;

   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [WX-1:0] wr_x;
   logic signed [WX-1:0] wr_y;
   logic                 move;
   logic [CW-1:0]        cm1;
   logic [CW-1:0]        cm2;
   logic [AW:0]          mid_sum;
   logic signed [DW-1:0] den;
   logic signed [SW-1:0] sum;
   logic                 accept;

   assign accept  = req_tvalid && req_tready;
   assign cm1     = count_ff - CW'(1);
   assign cm2     = count_ff - CW'(2);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign move    = front_ff || (rx_ff > xv_ff);
   assign den     = DW'(rx_ff) - DW'(xs0_ff);
   assign sum     = md_rsp.neg ? SW'(ya_ff) - $signed({1'b0, md_rsp.q})
                               : SW'(ya_ff) + $signed({1'b0, md_rsp.q});

   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = idx_ff + AW'(1);
      wr_x    = xv_ff;
      wr_y    = yv_ff;
      unique case (state_ff)
         S_INS_X0, S_LK_X0: rd_addr = cm1[AW-1:0];
         S_INS_EVAL: begin
            rd_addr = idx_ff - AW'(1);
            wr_en   = 1'b1;
            if (move) begin
               wr_x = rx_ff;
               wr_y = ry_ff;
            end
         end
         S_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
         end
         S_LK_SRCH: rd_addr = mid_sum[AW:1];
         S_LK_F0:   rd_addr = s0_ff;
         S_LK_F1:   rd_addr = s1_ff;
         default:   rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
      rx_ff <= x_mem[rd_addr];
      ry_ff <= y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         md_req_ff    <= '0;
      end else begin
         md_req_ff.start <= state_ff == S_LK_GO;
         if (rsp_valid_ff && rsp_tready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  xv_ff  <= req_tdata[31:0];
                  yv_ff  <= req_tdata[63:32];
                  res_ff <= '0;
                  st_ff  <= ST_OK;
                  unique case (req_tuser)
                     CMD_ADD: begin
                        if (count_ff >= CW'(MAX_POINTS)) begin
                           st_ff    <= ST_FULL;
                           state_ff <= S_EMIT;
                        end else if (count_ff == '0) begin
                           idx_ff   <= '0;
                           state_ff <= S_INS_WR;
                        end else begin
                           state_ff <= S_INS_X0;
                        end
                     end
                     CMD_LOOKUP: begin
                        if (count_ff == '0) begin
                           st_ff    <= ST_EMPTY;
                           state_ff <= S_EMIT;
                        end else begin
                           state_ff <= S_LK_X0;
                        end
                     end
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_EMIT;
                     end
                     default: state_ff <= S_EMIT;
                  endcase
               end
            end
            S_INS_X0: begin
               front_ff <= xv_ff <= rx_ff;
               idx_ff   <= cm1[AW-1:0];
               state_ff <= S_INS_EVAL;
            end
            S_INS_EVAL: begin
               if (move) begin
                  if (idx_ff == '0) begin
                     state_ff <= S_INS_WR;
                  end else begin
                     idx_ff <= idx_ff - AW'(1);
                  end
               end else begin
                  count_ff <= count_ff + CW'(1);
                  state_ff <= S_EMIT;
               end
            end
            S_INS_WR: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= S_EMIT;
            end
            S_LK_X0: begin
               if (count_ff == CW'(1)) begin
                  res_ff   <= ry_ff;
                  state_ff <= S_EMIT;
               end else begin
                  x0_ff    <= rx_ff;
                  state_ff <= S_LK_XL;
               end
            end
            S_LK_XL: begin
               if (xv_ff < x0_ff) begin
                  s0_ff     <= '0;
                  s1_ff     <= AW'(1);
                  anc_hi_ff <= 1'b0;
                  state_ff  <= S_LK_F0;
               end else if (xv_ff >= rx_ff) begin
                  s0_ff     <= cm2[AW-1:0];
                  s1_ff     <= cm1[AW-1:0];
                  anc_hi_ff <= 1'b1;
                  state_ff  <= S_LK_F0;
               end else begin
                  lo_ff    <= AW'(1);
                  hi_ff    <= cm1[AW-1:0];
                  state_ff <= S_LK_SRCH;
               end
            end
            S_LK_SRCH: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_sum[AW:1];
                  state_ff <= S_LK_SCMP;
               end else begin
                  s0_ff     <= lo_ff - AW'(1);
                  s1_ff     <= lo_ff;
                  anc_hi_ff <= 1'b0;
                  state_ff  <= S_LK_F0;
               end
            end
            S_LK_SCMP: begin
               if (rx_ff > xv_ff) begin
                  hi_ff <= mid_ff;
               end else begin
                  lo_ff <= mid_ff + AW'(1);
               end
               state_ff <= S_LK_SRCH;
            end
            S_LK_F0: state_ff <= S_LK_F1;
            S_LK_F1: begin
               xs0_ff   <= rx_ff;
               ys0_ff   <= ry_ff;
               state_ff <= S_LK_F2;
            end
            S_LK_F2: begin
               if (den[DW-1] || den == '0) begin
                  st_ff    <= ST_ZERO_WIDTH;
                  state_ff <= S_EMIT;
               end else begin
                  md_req_ff.den <= den[WX-1:0];
                  md_req_ff.dy  <= DW'(ry_ff) - DW'(ys0_ff);
                  md_req_ff.dx  <= DW'(xv_ff) - DW'(anc_hi_ff ? rx_ff : xs0_ff);
                  ya_ff         <= anc_hi_ff ? ry_ff : ys0_ff;
                  state_ff      <= S_LK_GO;
               end
            end
            S_LK_GO: state_ff <= S_LK_DIV;
            S_LK_DIV: begin
               if (md_rsp.done) begin
                  if (sum > SW'(32'sh7fffffff)) begin
                     res_ff <= 32'sh7fffffff;
                     st_ff  <= ST_SAT;
                  end else if (sum < -SW'(33'sh080000000)) begin
                     res_ff <= 32'sh80000000;
                     st_ff  <= ST_SAT;
                  end else begin
                     res_ff <= sum[WX-1:0];
                  end
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_y_ff     <= res_ff;
                  rsp_st_ff    <= st_ff;
                  rsp_cnt_ff   <= count_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   plt_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req_ff),
      .md_rsp (md_rsp)
   );

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_y_ff};
   assign rsp_tuser  = rsp_st_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("entry count above table size");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> {1'b0, wr_addr} <= count_ff)
      else $error("table write beyond filled entries");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> state_ff == S_LK_DIV)
      else $error("divider finished outside lookup");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_EVAL || state_ff == S_INS_WR) |-> count_ff < CW'(MAX_POINTS))
      else $error("insert into full table");
`endif
endmodule
